[rtl/secg_pkg.sv]
`default_nettype none

package secg_pkg;

  // Beat period and the widths that follow from it.
  localparam int unsigned SPP   = 500;
  localparam int unsigned CNT_W = $clog2(SPP);
  localparam int unsigned POS_W = 9;

  // floor(i*256/SPP) = (i * PH_RECIP) >> PH_SHIFT for every position i.
  localparam int unsigned PH_SHIFT = 20;
  localparam int unsigned PH_RECIP = (256 * (1 << PH_SHIFT) + SPP - 1) / SPP;
  localparam int unsigned PH_W     = CNT_W + PH_SHIFT;

  // floor(d*250/SPP) = (d * J_RECIP) >> J_SHIFT for distances d up to SPP.
  localparam int unsigned J_SHIFT = 16;
  localparam int unsigned J_RECIP = (250 * (1 << J_SHIFT) + SPP - 1) / SPP;
  localparam int unsigned NUM_W   = CNT_W + 1 + J_SHIFT;

  // Noise generator.
  localparam logic [31:0] LCG_MUL  = 32'd1103515245;
  localparam logic [31:0] LCG_INC  = 32'd12345;
  localparam logic [31:0] LCG_SEED = 32'd42;
  localparam logic [31:0] LCG_STEP = 32'd7;
  // A heartbeat restart seeds with SEED + STEP*beat and steps once, which folds
  // into one multiply-add: beat * (STEP*MUL) + (SEED*MUL + INC), all modulo 2^32.
  localparam logic [31:0] LCG_RESTART_MUL = 32'(64'(LCG_STEP) * 64'(LCG_MUL));
  localparam logic [31:0] LCG_RESTART_INC =
      32'(64'(LCG_SEED) * 64'(LCG_MUL) + 64'(LCG_INC));

  // Noise is r mod 101 minus 50; floor(x/101) = (x * RECIP) >> 28 for x < 2^16.
  localparam int unsigned NOISE_MOD   = 101;
  localparam int unsigned NOISE_BIAS  = 50;
  localparam int unsigned MOD_RECIP   = 2657777;
  localparam int unsigned MOD_SHIFT   = 28;

  localparam logic signed [15:0] AMP_RESET = 16'sd256;

  typedef enum logic [0:0] {
    WAVE_BEAT = 1'b0,
    WAVE_SINE = 1'b1
  } wave_e;

  typedef enum logic [0:0] {
    CFG_WAVEFORM       = 1'b0,
    CFG_SINE_AMPLITUDE = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [CNT_W-1:0] pos;
    logic [31:0]      noise;
  } item_t;

  localparam logic [7:0] SINE_QUARTER [64] = '{
    8'd0,   8'd6,   8'd13,  8'd19,  8'd25,  8'd31,  8'd38,  8'd44,
    8'd50,  8'd56,  8'd62,  8'd68,  8'd74,  8'd80,  8'd86,  8'd92,
    8'd98,  8'd104, 8'd109, 8'd115, 8'd121, 8'd126, 8'd132, 8'd137,
    8'd142, 8'd147, 8'd152, 8'd157, 8'd162, 8'd167, 8'd171, 8'd176,
    8'd180, 8'd184, 8'd188, 8'd192, 8'd196, 8'd199, 8'd203, 8'd206,
    8'd209, 8'd212, 8'd215, 8'd218, 8'd220, 8'd223, 8'd225, 8'd227,
    8'd229, 8'd231, 8'd233, 8'd234, 8'd236, 8'd237, 8'd238, 8'd239,
    8'd240, 8'd241, 8'd241, 8'd242, 8'd242, 8'd242, 8'd243, 8'd243
  };

  localparam int unsigned QRS_LEN = 80;

  localparam logic [8:0] QRS_PULSE [QRS_LEN] = '{
    9'd256, 9'd256, 9'd255, 9'd254, 9'd253, 9'd251, 9'd249, 9'd246, 9'd243, 9'd240,
    9'd236, 9'd232, 9'd228, 9'd224, 9'd219, 9'd214, 9'd209, 9'd203, 9'd198, 9'd192,
    9'd186, 9'd180, 9'd174, 9'd168, 9'd161, 9'd155, 9'd149, 9'd143, 9'd137, 9'd131,
    9'd125, 9'd119, 9'd113, 9'd107, 9'd102, 9'd96,  9'd91,  9'd86,  9'd81,  9'd76,
    9'd71,  9'd67,  9'd62,  9'd58,  9'd54,  9'd51,  9'd47,  9'd44,  9'd41,  9'd38,
    9'd35,  9'd32,  9'd29,  9'd27,  9'd25,  9'd23,  9'd21,  9'd19,  9'd17,  9'd16,
    9'd14,  9'd13,  9'd12,  9'd11,  9'd10,  9'd9,   9'd8,   9'd7,   9'd6,   9'd6,
    9'd5,   9'd5,   9'd4,   9'd4,   9'd3,   9'd3,   9'd3,   9'd2,   9'd2,   9'd2
  };

  // Full sine period of 256 phases built from the quarter table.
  function automatic logic signed [8:0] sine_of(input logic [7:0] p);
    logic [5:0] k;
    logic [8:0] mag;
    k   = p[6] ? ~p[5:0] : p[5:0];
    mag = {1'b0, SINE_QUARTER[k]};
    return p[7] ? -$signed(mag) : $signed(mag);
  endfunction

  // Gaussian pulse, zero past the end of the table.
  function automatic logic [8:0] qrs_of(input logic [7:0] j);
    logic [8:0] v;
    v = '0;
    if (j < 8'(QRS_LEN)) begin
      v = QRS_PULSE[j[6:0]];
    end
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/secg_state.sv]
`default_nettype none

module secg_state (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic             restart_i,
  input  logic [15:0]      beat_number_i,
  input  secg_pkg::wave_e  waveform_i,
  output secg_pkg::item_t  item_o
);
  import secg_pkg::*;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [31:0]      lcg_q, lcg_d;
  item_t            item_q;

  logic [CNT_W-1:0] pos;
  logic [31:0]      mul_a, mul_b, mul_c, stepped, seeded;

  always_comb begin
    pos = restart_i ? '0 : cnt_q;
    cnt_d = (pos == CNT_W'(SPP - 1)) ? '0 : pos + CNT_W'(1);

    // One multiply-add serves both the normal step and the reseed-and-step.
    mul_a   = restart_i ? 32'(beat_number_i) : lcg_q;
    mul_b   = restart_i ? LCG_RESTART_MUL : LCG_MUL;
    mul_c   = restart_i ? LCG_RESTART_INC : LCG_INC;
    stepped = mul_a * mul_b + mul_c;
    seeded  = LCG_SEED + 32'(beat_number_i) * LCG_STEP;

    if (waveform_i == WAVE_BEAT) begin
      lcg_d = stepped;
    end else begin
      lcg_d = restart_i ? seeded : lcg_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      lcg_q <= LCG_SEED;
    end else if (accept_i) begin
      cnt_q <= cnt_d;
      lcg_q <= lcg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      item_q.pos   <= pos;
      item_q.noise <= lcg_d;
    end
  end

  assign item_o = item_q;

  a_cnt_in_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, cnt_q} < (CNT_W + 1)'(SPP))
    else $error("sample counter left the period");

  a_restart_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && restart_i |=> item_q.pos == '0 && cnt_q == CNT_W'(1 % SPP))
    else $error("restart did not return to position zero");

endmodule

`default_nettype wire

[rtl/synthetic_ecg_sample_generator_top.sv]
`default_nettype none

// Synthetic ECG source: every accepted item yields one signed 8-bit sample in
// converter counts together with its position in the 500-sample beat period
// and a flag on the period's last sample. In heartbeat mode the sample is a
// Gaussian QRS pulse plus a slow sine baseline plus LCG noise; in sine mode it
// is the programmed Q8.8 amplitude times a sine over the period. An item with
// restart set goes back to position zero and reseeds the noise from its beat
// number. The block takes one item per clock while the output is not stalled,
// and each result passes through the stage 1 to stage 5 registers into the
// output register; the whole pipeline advances when the output register
// is empty or being taken. The clock is bounded by the noise generator update,
// a 32-bit constant multiply-add from the state register back to itself.
// Configuration writes take effect at once and belong to idle periods.

module synthetic_ecg_sample_generator_top (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    restart_i,
  input  logic [15:0]             beat_number_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [7:0]       sample_o,
  output logic [8:0]              position_o,
  output logic                    period_end_o,
  input  logic                    cfg_we_i,
  input  secg_pkg::cfg_reg_e      cfg_idx_i,
  input  logic [15:0]             cfg_wdata_i
);
  import secg_pkg::*;

  localparam logic [7:0] J_MAX = 8'd250;

  // Configuration.
  wave_e             waveform_q;
  logic signed [15:0] amp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waveform_q <= WAVE_BEAT;
      amp_q      <= AMP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WAVEFORM:       waveform_q <= wave_e'(cfg_wdata_i[0]);
        CFG_SINE_AMPLITUDE: amp_q      <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // Pipeline control: every stage moves when the output register frees up.
  logic adv, accept;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, out_valid_q;

  assign adv        = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && adv;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= accept;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      out_valid_q <= v5_q;
    end
  end

  // Stage 1: position counter and noise generator.
  item_t item;

  secg_state u_state (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .restart_i     (restart_i),
    .beat_number_i (beat_number_i),
    .waveform_i    (waveform_q),
    .item_o        (item)
  );

  // Stage 2: phase, scaled distance from mid-period, folded noise word.
  logic [CNT_W:0]   twice, span;
  logic [PH_W-1:0]  ph_full;
  logic [POS_W-1:0] s2_pos_q;
  logic             s2_pend_q;
  logic [7:0]       s2_ph_q;
  logic [NUM_W-1:0] s2_num_q;
  logic [15:0]      s2_fold_q;

  always_comb begin
    twice   = {item.pos, 1'b0};
    span    = (twice >= (CNT_W + 1)'(SPP)) ? twice - (CNT_W + 1)'(SPP)
                                           : (CNT_W + 1)'(SPP) - twice;
    ph_full = PH_W'(item.pos) * PH_W'(PH_RECIP);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_pos_q  <= POS_W'(item.pos);
      s2_pend_q <= (item.pos == CNT_W'(SPP - 1));
      s2_ph_q   <= ph_full[PH_SHIFT +: 8];
      s2_num_q  <= NUM_W'(span) * NUM_W'(J_RECIP);
      // 2^8, 2^16 and 2^24 are 54, 88 and 5 modulo 101.
      s2_fold_q <= 16'(item.noise[31:24]) * 16'd5 + 16'(item.noise[23:16]) * 16'd88
                 + 16'(item.noise[15:8]) * 16'd54 + 16'(item.noise[7:0]);
    end
  end

  // Stage 3: pulse index, noise quotient, baseline phase, sine product.
  logic [37:0]        mq;
  logic [17:0]        ph3_full;
  logic [POS_W-1:0]   s3_pos_q;
  logic               s3_pend_q;
  logic [7:0]         s3_j_q;
  logic [15:0]        s3_fold_q;
  logic [8:0]         s3_q_q;
  logic [6:0]         s3_ph3_q;
  logic signed [24:0] s3_prod_q;

  always_comb begin
    mq       = 38'(s2_fold_q) * 38'(MOD_RECIP);
    ph3_full = 18'(s2_ph_q) * 18'd683;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_pos_q  <= s2_pos_q;
      s3_pend_q <= s2_pend_q;
      s3_j_q    <= s2_num_q[J_SHIFT +: 8];
      s3_fold_q <= s2_fold_q;
      s3_q_q    <= mq[MOD_SHIFT +: 9];
      s3_ph3_q  <= ph3_full[17:11];
      s3_prod_q <= amp_q * sine_of(s2_ph_q);
    end
  end

  // Stage 4: pulse and baseline lookups, noise remainder, sine-mode sample.
  logic [15:0]        m_full;
  logic signed [27:0] p_ext, p5, p_div;
  logic signed [7:0]  sine_val;
  logic [POS_W-1:0]   s4_pos_q;
  logic               s4_pend_q;
  logic [8:0]         s4_e_q;
  logic [6:0]         s4_m_q;
  logic signed [8:0]  s4_sb_q;
  logic signed [7:0]  s4_sine_q;

  always_comb begin
    m_full = s3_fold_q - 16'(s3_q_q) * 16'(NOISE_MOD);
    p_ext  = {{3{s3_prod_q[24]}}, s3_prod_q};
    p5     = (p_ext <<< 2) + p_ext;
    // Division by 8192 truncating toward zero.
    p_div  = p5[27] ? (p5 + 28'sd8191) >>> 13 : p5 >>> 13;
    if (p_div > 28'sd127) begin
      sine_val = 8'sd127;
    end else if (p_div < -28'sd128) begin
      sine_val = -8'sd128;
    end else begin
      sine_val = p_div[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_pos_q  <= s3_pos_q;
      s4_pend_q <= s3_pend_q;
      s4_e_q    <= qrs_of(s3_j_q);
      s4_m_q    <= m_full[6:0];
      s4_sb_q   <= sine_of({1'b0, s3_ph3_q});
      s4_sine_q <= sine_val;
    end
  end

  // Stage 5: heartbeat sum in units of 1/3200 count.
  logic signed [18:0] e_s, sb_s, n_s, acc;
  logic [POS_W-1:0]   s5_pos_q;
  logic               s5_pend_q;
  logic signed [18:0] s5_acc_q;
  logic signed [7:0]  s5_sine_q;

  always_comb begin
    e_s  = $signed({10'b0, s4_e_q});
    sb_s = {{10{s4_sb_q[8]}}, s4_sb_q};
    n_s  = $signed({12'b0, s4_m_q}) - 19'sd50;
    acc  = e_s * 19'sd400 + sb_s * 19'sd25 + (n_s <<< 8);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_pos_q  <= s4_pos_q;
      s5_pend_q <= s4_pend_q;
      s5_acc_q  <= acc;
      s5_sine_q <= s4_sine_q;
    end
  end

  // Stage 6: divide by 3200 toward zero (shift by 7, then by 25 via
  // reciprocal) and select the mode's sample.
  logic              acc_neg;
  logic [18:0]       mag;
  logic [23:0]       qd_full;
  logic [7:0]        qd;
  logic signed [7:0] beat_val;

  logic signed [7:0] sample_q;
  logic [8:0]        position_q;
  logic              period_end_q;

  always_comb begin
    acc_neg  = s5_acc_q[18];
    mag      = acc_neg ? 19'(-s5_acc_q) : 19'(s5_acc_q);
    qd_full  = 24'(mag[17:7]) * 24'd5243;
    qd       = {1'b0, qd_full[23:17]};
    beat_val = acc_neg ? -$signed(qd) : $signed(qd);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sample_q     <= (waveform_q == WAVE_SINE) ? s5_sine_q : beat_val;
      position_q   <= s5_pos_q;
      period_end_q <= s5_pend_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_o     = sample_q;
  assign position_o   = position_q;
  assign period_end_o = period_end_q;

  a_noise_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q |-> s4_m_q < 7'(NOISE_MOD))
    else $error("noise remainder out of range");

  a_pulse_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> s3_j_q <= J_MAX)
    else $error("pulse index beyond half period");

  a_period_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && period_end_q |-> position_q == POS_W'(SPP - 1))
    else $error("period end flagged away from the last position");

endmodule

`default_nettype wire
